/* rtl/core/ccc_pkg.sv */
package ccc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        t_reg_start_day    = 3'd0,
        t_reg_start_month  = 3'd1,
        t_reg_start_year   = 3'd2,
        t_reg_start_hour   = 3'd3,
        t_reg_start_minute = 3'd4,
        t_reg_start_second = 3'd5
    } t_cfg_reg;

    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;

    localparam int SEC_LAST   = 59;
    localparam int MIN_LAST   = 59;
    localparam int HOUR_LAST  = 23;
    localparam int MONTH_LAST = 12;
    localparam int YEAR_LAST  = 9999;

    localparam int YEAR_RST  = 2000;
    localparam int DAY_RST   = 1;
    localparam int MONTH_RST = 1;

    // divisibility by 25 through the inverse of 25 modulo 2**16
    localparam logic [15:0] INV25    = 16'h5C29;
    localparam logic [15:0] DIV25_MAX = 16'(65535 / 25);

    typedef struct packed {
        logic load;
        logic step;
    } t_cell_ctrl;

    function automatic logic f_leap(input logic [15:0] y);
        logic [15:0] prod;
        logic        div25;
        prod  = y * INV25;
        div25 = (prod <= DIV25_MAX);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2: begin
                len = leap ? 5'd29 : 5'd28;
            end
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
                len = 5'd31;
            end
            default: begin
                len = 5'd30;
            end
        endcase
        return len;
    endfunction

endpackage

/* rtl/core/calendar_clock_counter_top.sv */
// latency: the result of a request is shown the cycle after it is taken
// throughput: one request per cycle when not stalled; six cells ripple carries in that cycle
// the counters drive the result ports directly and hold while the result is stalled
// reset (synchronous, active low): 00:00:00 on 1 January 2000, start registers alike
module calendar_clock_counter_top #(
    parameter int YEAR_WIDTH = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_load,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ccc_pkg::DAY_W-1:0]           o_day_out,
    output logic [ccc_pkg::MONTH_W-1:0]         o_month_out,
    output logic [YEAR_WIDTH-1:0]               o_year_out,
    output logic [ccc_pkg::HOUR_W-1:0]          o_hour_out,
    output logic [ccc_pkg::MIN_W-1:0]           o_minute_out,
    output logic [ccc_pkg::SEC_W-1:0]           o_second_out,
    output logic                                o_leap_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ccc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ccc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int YEAR_LIMIT = (ccc_pkg::YEAR_LAST < (1 << YEAR_WIDTH)) ?
                                ccc_pkg::YEAR_LAST : (1 << YEAR_WIDTH);
    localparam logic [YEAR_WIDTH-1:0] YEAR_RST_V = YEAR_WIDTH'(ccc_pkg::YEAR_RST);
    localparam logic LEAP_RST = ccc_pkg::f_leap(16'(YEAR_RST_V));

    logic [ccc_pkg::DAY_W-1:0]   r_start_day;
    logic [ccc_pkg::MONTH_W-1:0] r_start_month;
    logic [YEAR_WIDTH-1:0]       r_start_year;
    logic [ccc_pkg::HOUR_W-1:0]  r_start_hour;
    logic [ccc_pkg::MIN_W-1:0]   r_start_minute;
    logic [ccc_pkg::SEC_W-1:0]   r_start_second;

    logic r_out_valid;
    logic r_leap;
    logic accept;

    ccc_pkg::t_cell_ctrl sec_ctrl, min_ctrl, hour_ctrl, day_ctrl, month_ctrl, year_ctrl;
    logic sec_carry, min_carry, hour_carry, day_carry, month_carry, year_carry;

    logic [YEAR_WIDTH-1:0]       year_next;
    logic [ccc_pkg::DAY_W-1:0]   month_len;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out_valid && i_stall;
    assign accept      = i_valid && !o_stall;
    assign o_valid     = r_out_valid;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_day    <= ccc_pkg::DAY_W'(ccc_pkg::DAY_RST);
            r_start_month  <= ccc_pkg::MONTH_W'(ccc_pkg::MONTH_RST);
            r_start_year   <= YEAR_RST_V;
            r_start_hour   <= '0;
            r_start_minute <= '0;
            r_start_second <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ccc_pkg::t_reg_start_day: begin
                    r_start_day <= i_cfg_data[ccc_pkg::DAY_W-1:0];
                end
                ccc_pkg::t_reg_start_month: begin
                    r_start_month <= i_cfg_data[ccc_pkg::MONTH_W-1:0];
                end
                ccc_pkg::t_reg_start_year: begin
                    r_start_year <= i_cfg_data[YEAR_WIDTH-1:0];
                end
                ccc_pkg::t_reg_start_hour: begin
                    r_start_hour <= i_cfg_data[ccc_pkg::HOUR_W-1:0];
                end
                ccc_pkg::t_reg_start_minute: begin
                    r_start_minute <= i_cfg_data[ccc_pkg::MIN_W-1:0];
                end
                ccc_pkg::t_reg_start_second: begin
                    r_start_second <= i_cfg_data[ccc_pkg::SEC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // carry chain
    always_comb begin
        sec_ctrl.load   = accept && i_load;
        sec_ctrl.step   = accept && !i_load;
        min_ctrl.load   = sec_ctrl.load;
        min_ctrl.step   = sec_carry;
        hour_ctrl.load  = sec_ctrl.load;
        hour_ctrl.step  = min_carry;
        day_ctrl.load   = sec_ctrl.load;
        day_ctrl.step   = hour_carry;
        month_ctrl.load = sec_ctrl.load;
        month_ctrl.step = day_carry;
        year_ctrl.load  = sec_ctrl.load;
        year_ctrl.step  = month_carry;
    end

    assign month_len = ccc_pkg::f_month_len(o_month_out, r_leap);

    ccc_cell #(
        .WIDTH(ccc_pkg::SEC_W), .RST_VAL('0), .WRAP_VAL('0)
    ) u_sec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(sec_ctrl),
        .i_load_val(r_start_second),
        .i_limit((ccc_pkg::SEC_W+1)'(ccc_pkg::SEC_LAST)),
        .o_value(o_second_out), .o_carry(sec_carry)
    );

    ccc_cell #(
        .WIDTH(ccc_pkg::MIN_W), .RST_VAL('0), .WRAP_VAL('0)
    ) u_min (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(min_ctrl),
        .i_load_val(r_start_minute),
        .i_limit((ccc_pkg::MIN_W+1)'(ccc_pkg::MIN_LAST)),
        .o_value(o_minute_out), .o_carry(min_carry)
    );

    ccc_cell #(
        .WIDTH(ccc_pkg::HOUR_W), .RST_VAL('0), .WRAP_VAL('0)
    ) u_hour (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(hour_ctrl),
        .i_load_val(r_start_hour),
        .i_limit((ccc_pkg::HOUR_W+1)'(ccc_pkg::HOUR_LAST)),
        .o_value(o_hour_out), .o_carry(hour_carry)
    );

    ccc_cell #(
        .WIDTH(ccc_pkg::DAY_W),
        .RST_VAL(ccc_pkg::DAY_W'(ccc_pkg::DAY_RST)),
        .WRAP_VAL(ccc_pkg::DAY_W'(1))
    ) u_day (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(day_ctrl),
        .i_load_val(r_start_day),
        .i_limit({1'b0, month_len}),
        .o_value(o_day_out), .o_carry(day_carry)
    );

    ccc_cell #(
        .WIDTH(ccc_pkg::MONTH_W),
        .RST_VAL(ccc_pkg::MONTH_W'(ccc_pkg::MONTH_RST)),
        .WRAP_VAL(ccc_pkg::MONTH_W'(1))
    ) u_month (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(month_ctrl),
        .i_load_val(r_start_month),
        .i_limit((ccc_pkg::MONTH_W+1)'(ccc_pkg::MONTH_LAST)),
        .o_value(o_month_out), .o_carry(month_carry)
    );

    ccc_cell #(
        .WIDTH(YEAR_WIDTH), .RST_VAL(YEAR_RST_V), .WRAP_VAL('0)
    ) u_year (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(year_ctrl),
        .i_load_val(r_start_year),
        .i_limit((YEAR_WIDTH+1)'(YEAR_LIMIT)),
        .o_value(o_year_out), .o_carry(year_carry)
    );

    // year as it will stand after this edge
    always_comb begin
        if (year_ctrl.load) begin
            year_next = r_start_year;
        end else if (year_carry) begin
            year_next = '0;
        end else if (year_ctrl.step) begin
            year_next = o_year_out + 1'b1;
        end else begin
            year_next = o_year_out;
        end
    end

    // leap flag follows the year register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leap      <= LEAP_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_leap <= ccc_pkg::f_leap(16'(year_next));
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_leap_out = r_leap;

`ifndef NO_ASSERTIONS
    a_leap_tracks_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_leap == ccc_pkg::f_leap(16'(o_year_out)))
        else $error("leap flag out of step with year");

    a_load_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_load |=> o_day_out == $past(r_start_day))
        else $error("load did not copy start day");

    a_tick_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_load && (o_second_out < 6'(ccc_pkg::SEC_LAST))
        |=> o_second_out == $past(o_second_out) + 6'd1)
        else $error("second did not advance");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(o_second_out) && $stable(o_year_out) && $stable(o_day_out))
        else $error("counters moved without a request");

    a_year_only_on_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        year_carry |-> month_carry && day_carry && hour_carry)
        else $error("carry chain broken");
`endif

endmodule

/* rtl/core/ccc_cell.sv */
module ccc_cell #(
    parameter int               WIDTH    = 6,
    parameter logic [WIDTH-1:0] RST_VAL  = '0,
    parameter logic [WIDTH-1:0] WRAP_VAL = '0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ccc_pkg::t_cell_ctrl i_ctrl,
    input  logic [WIDTH-1:0]    i_load_val,
    input  logic [WIDTH:0]      i_limit,
    output logic [WIDTH-1:0]    o_value,
    output logic                o_carry
);

    logic [WIDTH-1:0] r_value;
    logic [WIDTH-1:0] n_value;
    logic [WIDTH:0]   sum;
    logic             wrap;

    assign sum  = {1'b0, r_value} + {{WIDTH{1'b0}}, 1'b1};
    assign wrap = (sum > i_limit);

    always_comb begin
        if (i_ctrl.load) begin
            n_value = i_load_val;
        end else if (i_ctrl.step) begin
            n_value = wrap ? WRAP_VAL : sum[WIDTH-1:0];
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= RST_VAL;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;
    assign o_carry = i_ctrl.step && !i_ctrl.load && wrap;

endmodule

/* tb/calendar_clock_checker.sv */
`timescale 1ns / 1ps

module calendar_clock_checker #(
    parameter int YEAR_WIDTH = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    input  logic                              i_req_stall,
    input  logic                              i_req_load,
    input  logic                              i_res_valid,
    input  logic                              i_res_stall,
    input  logic [ccc_pkg::DAY_W-1:0]         i_day,
    input  logic [ccc_pkg::MONTH_W-1:0]       i_month,
    input  logic [YEAR_WIDTH-1:0]             i_year,
    input  logic [ccc_pkg::HOUR_W-1:0]        i_hour,
    input  logic [ccc_pkg::MIN_W-1:0]         i_minute,
    input  logic [ccc_pkg::SEC_W-1:0]         i_second,
    input  logic                              i_leap,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [ccc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ccc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import ccc_pkg::*;

    typedef struct packed {
        logic [DAY_W-1:0]      day;
        logic [MONTH_W-1:0]    month;
        logic [YEAR_WIDTH-1:0] year;
        logic [HOUR_W-1:0]     hour;
        logic [MIN_W-1:0]      minute;
        logic [SEC_W-1:0]      second;
        logic                  leap;
    } reading_t;

    reading_t clock_now;
    reading_t start_time;
    reading_t expected_readings[$];

    function automatic logic leap_year(input int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int days_in_month(input int m, input int y);
        int len;
        case (m)
            2: begin
                len = leap_year(y) ? 29 : 28;
            end
            1, 3, 5, 7, 8, 10, 12: begin
                len = 31;
            end
            default: begin
                len = 30;
            end
        endcase
        return len;
    endfunction

    // carries ripple upwards; out-of-range counters clear or wrap on their next carry
    function automatic reading_t advance_second(input reading_t t);
        int s;
        int m;
        int h;
        int d;
        int mo;
        int y;
        reading_t n;
        s  = int'(t.second) + 1;
        m  = t.minute;
        h  = t.hour;
        d  = t.day;
        mo = t.month;
        y  = t.year;
        if (s > SEC_LAST) begin
            s = 0;
            m = m + 1;
            if (m > MIN_LAST) begin
                m = 0;
                h = h + 1;
                if (h > HOUR_LAST) begin
                    h = 0;
                    if (d + 1 > days_in_month(mo, y)) begin
                        d  = 1;
                        mo = mo + 1;
                        if (mo > MONTH_LAST) begin
                            mo = 1;
                            y  = (y >= YEAR_LAST) ? 0 : y + 1;
                        end
                    end else begin
                        d = d + 1;
                    end
                end
            end
        end
        n        = t;
        n.second = SEC_W'(s);
        n.minute = MIN_W'(m);
        n.hour   = HOUR_W'(h);
        n.day    = DAY_W'(d);
        n.month  = MONTH_W'(mo);
        n.year   = YEAR_WIDTH'(y);
        return n;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        reading_t want;
        if (!i_rst_n) begin
            clock_now         = '0;
            clock_now.day     = DAY_W'(DAY_RST);
            clock_now.month   = MONTH_W'(MONTH_RST);
            clock_now.year    = YEAR_WIDTH'(YEAR_RST);
            start_time        = clock_now;
            expected_readings.delete();
            o_fail_count      = 0;
        end else begin
            // the result shown at this edge belongs to an earlier request
            if (i_res_valid && !i_res_stall) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t: result with no request waiting", $time);
                    o_fail_count++;
                end else begin
                    want = expected_readings.pop_front();
                    compare_field("day", want.day, i_day);
                    compare_field("month", want.month, i_month);
                    compare_field("year", want.year, i_year);
                    compare_field("hour", want.hour, i_hour);
                    compare_field("minute", want.minute, i_minute);
                    compare_field("second", want.second, i_second);
                    compare_field("leap", want.leap, i_leap);
                end
            end
            if (i_req_valid && !i_req_stall) begin
                if (i_req_load) begin
                    clock_now = start_time;
                end else begin
                    clock_now = advance_second(clock_now);
                end
                want      = clock_now;
                want.leap = leap_year(clock_now.year);
                expected_readings.push_back(want);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    t_reg_start_day: begin
                        start_time.day = i_cfg_data[DAY_W-1:0];
                    end
                    t_reg_start_month: begin
                        start_time.month = i_cfg_data[MONTH_W-1:0];
                    end
                    t_reg_start_year: begin
                        start_time.year = i_cfg_data[YEAR_WIDTH-1:0];
                    end
                    t_reg_start_hour: begin
                        start_time.hour = i_cfg_data[HOUR_W-1:0];
                    end
                    t_reg_start_minute: begin
                        start_time.minute = i_cfg_data[MIN_W-1:0];
                    end
                    t_reg_start_second: begin
                        start_time.second = i_cfg_data[SEC_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = expected_readings.size();
    end

endmodule

/* tb/tb_calendar_clock_counter_top.sv */
`timescale 1ns / 1ps

module tb_calendar_clock_counter_top;
    import ccc_pkg::*;

    localparam int YEAR_W      = 14;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_TARGET = 1450;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    req_valid = 1'b0;
    logic                    req_load  = 1'b0;
    logic                    req_stall;
    logic                    res_valid;
    logic                    res_stall = 1'b0;
    logic [DAY_W-1:0]        day_out;
    logic [MONTH_W-1:0]      month_out;
    logic [YEAR_W-1:0]       year_out;
    logic [HOUR_W-1:0]       hour_out;
    logic [MIN_W-1:0]        minute_out;
    logic [SEC_W-1:0]        second_out;
    logic                    leap_out;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    int fail_count;
    int pending;
    int sent      = 0;
    bit busy_run  = 1'b0;
    bit hold_req  = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    calendar_clock_counter_top #(
        .YEAR_WIDTH(YEAR_W)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (req_valid),
        .o_stall      (req_stall),
        .i_load       (req_load),
        .o_valid      (res_valid),
        .i_stall      (res_stall),
        .o_day_out    (day_out),
        .o_month_out  (month_out),
        .o_year_out   (year_out),
        .o_hour_out   (hour_out),
        .o_minute_out (minute_out),
        .o_second_out (second_out),
        .o_leap_out   (leap_out),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    calendar_clock_checker #(
        .YEAR_WIDTH(YEAR_W)
    ) checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req_load   (req_load),
        .i_res_valid  (res_valid),
        .i_res_stall  (res_stall),
        .i_day        (day_out),
        .i_month      (month_out),
        .i_year       (year_out),
        .i_hour       (hour_out),
        .i_minute     (minute_out),
        .i_second     (second_out),
        .i_leap       (leap_out),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] reg_word(input int value, input int width,
                                                      input bit noisy);
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] junk;
        mask = (CFG_DATA_W'(1) << width) - 1'b1;
        junk = noisy ? CFG_DATA_W'($urandom) : '0;
        return (CFG_DATA_W'(value) & mask) | (junk & ~mask);
    endfunction

    task automatic send_request(input logic load);
        int gap;
        gap = busy_run ? 0 : idle_length();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_load  <= load;
        do @(posedge clk); while (req_stall);
        sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_start(input int d, input int mo, input int y, input int h,
                             input int mi, input int s, input bit noisy, input bit partial);
        if (!partial || $urandom_range(0, 4) != 0) begin
            write_reg(t_reg_start_day, reg_word(d, DAY_W, noisy));
        end
        if (!partial || $urandom_range(0, 4) != 0) begin
            write_reg(t_reg_start_month, reg_word(mo, MONTH_W, noisy));
        end
        if (!partial || $urandom_range(0, 4) != 0) begin
            write_reg(t_reg_start_year, reg_word(y, YEAR_W, noisy));
        end
        if (!partial || $urandom_range(0, 4) != 0) begin
            write_reg(t_reg_start_hour, reg_word(h, HOUR_W, noisy));
        end
        if (!partial || $urandom_range(0, 4) != 0) begin
            write_reg(t_reg_start_minute, reg_word(mi, MIN_W, noisy));
        end
        if (!partial || $urandom_range(0, 4) != 0) begin
            write_reg(t_reg_start_second, reg_word(s, SEC_W, noisy));
        end
        // stray index beyond the last register, which the block ignores
        if (partial && $urandom_range(0, 3) == 0) begin
            write_reg(CFG_IDX_W'(t_reg_start_second + $urandom_range(1, 2)),
                      CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_start();
        int d;
        int mo;
        int y;
        int h;
        int mi;
        int r;
        d  = ($urandom_range(0, 9) < 6) ? $urandom_range(27, 31) : $urandom_range(0, 31);
        r  = $urandom_range(0, 9);
        mo = (r < 4) ? 12 : (r < 6) ? 2 : $urandom_range(0, 15);
        case ($urandom_range(0, 9))
            0: y = 0;
            1: y = 1900;
            2: y = 2000;
            3: y = 2100;
            4: y = 2400;
            5: y = YEAR_LAST - 1;
            6: y = YEAR_LAST;
            7: y = $urandom_range(YEAR_LAST + 1, (1 << YEAR_W) - 1);
            default: y = $urandom_range(0, YEAR_LAST);
        endcase
        h  = ($urandom_range(0, 9) < 7) ? HOUR_LAST : $urandom_range(0, 31);
        mi = ($urandom_range(0, 9) < 7) ? MIN_LAST : $urandom_range(0, 63);
        set_start(d, mo, y, h, mi, $urandom_range(0, 63), $urandom_range(0, 2) == 0, 1'b1);
    endtask

    // receiver side: random stalls plus one long hold-off on request
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                stall_left--;
                res_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                res_stall <= 1'b1;
            end else if (!busy_run && $urandom_range(0, 3) == 0) begin
                stall_left = idle_length();
                res_stall <= 1'b1;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (res_valid && !res_stall)
                    || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_drained();
        // end of year 9999 wraps to year 0
        set_start(31, 12, YEAR_LAST, 23, 59, 59, 1'b0, 1'b0);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        wait_drained();
        set_start(29, 2, 2000, 23, 59, 59, 1'b0, 1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_drained();
        set_start(28, 2, 1900, 23, 59, 59, 1'b0, 1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_drained();
        set_start(28, 2, 2024, 23, 59, 59, 1'b0, 1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_drained();
        // out-of-range counters, month zero and a year past the last
        set_start(31, 0, (1 << YEAR_W) - 1, 31, 63, 63, 1'b0, 1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_drained();
        set_start(31, 15, YEAR_LAST - 1, 24, 60, 60, 1'b0, 1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_drained();
        set_start(0, 4, 2100, 0, 0, 0, 1'b0, 1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_drained();

        phase = 0;
        while (sent < ITEM_TARGET) begin
            wait_drained();
            random_start();
            busy_run = (phase % 4 == 2);
            if (phase == 5) begin
                busy_run = 1'b1;
                hold_req = 1'b1;
            end
            send_request($urandom_range(0, 3) != 0);
            n = $urandom_range(30, 80);
            repeat (n) send_request($urandom_range(0, 11) == 0);
            phase++;
        end
        busy_run = 1'b0;
        wait_drained();
        repeat (5) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
